// ----- sv/dtm_pkg.sv -----
package dtm_pkg;

    // Parse phase within one string
    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_TAIL   = 4'b1000
    } phase_t;

    // Unit suffix recognizer
    typedef enum logic [6:0] {
        SFX_EMPTY = 7'b0000001,
        SFX_S     = 7'b0000010,
        SFX_M     = 7'b0000100,
        SFX_MS    = 7'b0001000,
        SFX_H     = 7'b0010000,
        SFX_D     = 7'b0100000,
        SFX_BAD   = 7'b1000000
    } suffix_t;

    // Result status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NAN      = 3'd1;
    localparam logic [2:0] STATUS_NEGATIVE = 3'd2;
    localparam logic [2:0] STATUS_SUFFIX   = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

    // Magnitude limits
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // Unit factors in milliseconds
    localparam int          FACTOR_W        = 27;
    localparam logic [63:0] SECONDS_PER_DAY = 64'd86400;
    localparam logic [63:0] FACTOR_MS_64    = 64'd1;
    localparam logic [63:0] FACTOR_S_64     = 64'd1000;
    localparam logic [63:0] FACTOR_M_64     = 64'd60000;
    localparam logic [63:0] FACTOR_H_64     = 64'd3600000;
    localparam logic [63:0] FACTOR_D_64     = SECONDS_PER_DAY * 64'd1000;

    localparam logic [FACTOR_W-1:0] FACTOR_MS = FACTOR_MS_64[FACTOR_W-1:0];
    localparam logic [FACTOR_W-1:0] FACTOR_S  = FACTOR_S_64[FACTOR_W-1:0];
    localparam logic [FACTOR_W-1:0] FACTOR_M  = FACTOR_M_64[FACTOR_W-1:0];
    localparam logic [FACTOR_W-1:0] FACTOR_H  = FACTOR_H_64[FACTOR_W-1:0];
    localparam logic [FACTOR_W-1:0] FACTOR_D  = FACTOR_D_64[FACTOR_W-1:0];

    // Largest magnitude per unit that keeps the product within 2^63-1
    localparam logic [63:0] LIMIT_MS = POS_LIMIT / FACTOR_MS_64;
    localparam logic [63:0] LIMIT_S  = POS_LIMIT / FACTOR_S_64;
    localparam logic [63:0] LIMIT_M  = POS_LIMIT / FACTOR_M_64;
    localparam logic [63:0] LIMIT_H  = POS_LIMIT / FACTOR_H_64;
    localparam logic [63:0] LIMIT_D  = POS_LIMIT / FACTOR_D_64;

    // Finished string summary handed from the parser to the scaler
    typedef struct packed {
        logic [63:0] magnitude;
        logic        minus_seen;
        logic        digit_seen;
        logic        range_exceeded;
        suffix_t     suffix;
    } parse_sum_t;

endpackage

// ----- sv/duration_text_to_milliseconds.sv -----
// Path: a last beat passes the summary, partial-product and result registers.
// Throughput: one beat per cycle unless stalled; a new string may follow at once.
// Stages: parse summary, split partial products of the unit scaling, final add.
// Reset: rst_n is asynchronous and active low; it clears the parse state and all
// stage valids, so no result is pending and the next beat starts a new string.
module duration_text_to_milliseconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        char_present,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [62:0] duration_ms,
    output logic [2:0]  status
);
    import dtm_pkg::*;

    parse_sum_t  sum_data;
    logic        sum_valid;
    logic        pp_valid;
    logic [58:0] pp_lo;
    logic [57:0] pp_hi;
    logic [2:0]  pp_status;
    logic        res_ready;
    logic        pp_ready;
    logic        sum_ready;
    logic        in_accept;

    // Stall chain: each stage moves when the next one has room
    assign res_ready = !out_valid || !out_stall;
    assign pp_ready  = !pp_valid || res_ready;
    assign sum_ready = !sum_valid || pp_ready;
    assign in_stall  = !sum_ready;
    assign in_accept = in_valid && sum_ready;

    dtm_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .char_code    (char_code),
        .char_present (char_present),
        .last_char    (last_char),
        .sum_take     (pp_ready),
        .sum_valid    (sum_valid),
        .sum_data     (sum_data)
    );

    dtm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (sum_valid && pp_ready),
        .drain     (res_ready),
        .sum_data  (sum_data),
        .pp_valid  (pp_valid),
        .pp_lo     (pp_lo),
        .pp_hi     (pp_hi),
        .pp_status (pp_status)
    );

    dtm_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (pp_valid && res_ready),
        .drain      (!out_stall),
        .pp_lo      (pp_lo),
        .pp_hi      (pp_hi),
        .pp_status  (pp_status),
        .res_valid  (out_valid),
        .res_ms     (duration_ms),
        .res_status (status)
    );

    // Any error status carries a zero duration
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> duration_ms == 63'd0)
        else $error("nonzero duration with error status");

    // Status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_NAN ||
                       status == STATUS_NEGATIVE || status == STATUS_SUFFIX ||
                       status == STATUS_OVERFLOW))
        else $error("undefined status code");

    // Input stalls only behind a full summary stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> sum_valid)
        else $error("input stalled with empty summary stage");

    // A last beat always leaves a summary behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_char) |=> sum_valid)
        else $error("last beat lost");

endmodule

// ----- sv/dtm_parse.sv -----
module dtm_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_code,
    input  logic                char_present,
    input  logic                last_char,
    input  logic                sum_take,
    output logic                sum_valid,
    output dtm_pkg::parse_sum_t sum_data
);
    import dtm_pkg::*;

    phase_t      phase_reg, phase_next;
    suffix_t     suffix_reg, suffix_next;
    logic [63:0] mag_reg, mag_next;
    logic        minus_reg, minus_next;
    logic        digit_reg, digit_next;
    logic        range_reg, range_next;
    logic        sum_valid_reg, sum_valid_next;
    parse_sum_t  sum_reg, sum_next;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [63:0] lim;
    logic [67:0] mag_wide;
    logic [63:0] mag_step;
    logic        range_step;
    suffix_t     suffix_step;

    // One decimal step: mag*10 + digit, checked against the sign's limit
    always_comb
    begin
        is_digit  = char_code inside {[8'h30:8'h39]};
        digit_val = char_code[3:0];
        lim       = minus_reg ? NEG_LIMIT : POS_LIMIT;
        mag_wide  = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {64'b0, digit_val};
        if (range_reg)
        begin
            mag_step   = mag_reg;
            range_step = 1'b1;
        end
        else if (mag_wide > {4'b0, lim})
        begin
            mag_step   = mag_reg;
            range_step = 1'b1;
        end
        else
        begin
            mag_step   = mag_wide[63:0];
            range_step = 1'b0;
        end
    end

    // Suffix recognizer step
    always_comb
    begin
        suffix_step = SFX_BAD;
        case (suffix_reg)
            SFX_EMPTY:
            begin
                if (char_code == "s")
                    suffix_step = SFX_S;
                else if (char_code == "m")
                    suffix_step = SFX_M;
                else if (char_code == "h")
                    suffix_step = SFX_H;
                else if (char_code == "d")
                    suffix_step = SFX_D;
            end
            SFX_M:
            begin
                if (char_code == "s")
                    suffix_step = SFX_MS;
            end
            default: suffix_step = SFX_BAD;
        endcase
    end

    // Per-character parse state update
    always_comb
    begin
        phase_next  = phase_reg;
        suffix_next = suffix_reg;
        mag_next    = mag_reg;
        minus_next  = minus_reg;
        digit_next  = digit_reg;
        range_next  = range_reg;
        if (char_present)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (char_code == "-")
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        digit_next = 1'b1;
                        phase_next = PH_DIGITS;
                        mag_next   = mag_step;
                        range_next = range_step;
                    end
                    else
                        phase_next = PH_TAIL;
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        digit_next = 1'b1;
                        phase_next = PH_DIGITS;
                        mag_next   = mag_step;
                        range_next = range_step;
                    end
                    else
                        phase_next = PH_TAIL;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        mag_next   = mag_step;
                        range_next = range_step;
                    end
                    else
                    begin
                        phase_next  = PH_TAIL;
                        suffix_next = suffix_step;
                    end
                end
                default:
                begin
                    if (digit_reg)
                        suffix_next = suffix_step;
                end
            endcase
        end

        // Summary of the finished string
        sum_next.magnitude      = mag_next;
        sum_next.minus_seen     = minus_next;
        sum_next.digit_seen     = digit_next;
        sum_next.range_exceeded = range_next;
        sum_next.suffix         = suffix_next;

        if (accept && last_char)
            sum_valid_next = 1'b1;
        else if (sum_take)
            sum_valid_next = 1'b0;
        else
            sum_valid_next = sum_valid_reg;
    end

    // Parse state: back to start after the last beat of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            suffix_reg    <= SFX_EMPTY;
            mag_reg       <= '0;
            minus_reg     <= 1'b0;
            digit_reg     <= 1'b0;
            range_reg     <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            if (accept)
            begin
                if (last_char)
                begin
                    phase_reg  <= PH_START;
                    suffix_reg <= SFX_EMPTY;
                    mag_reg    <= '0;
                    minus_reg  <= 1'b0;
                    digit_reg  <= 1'b0;
                    range_reg  <= 1'b0;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    suffix_reg <= suffix_next;
                    mag_reg    <= mag_next;
                    minus_reg  <= minus_next;
                    digit_reg  <= digit_next;
                    range_reg  <= range_next;
                end
            end
        end
    end

    // Summary register, payload only
    always_ff @(posedge clk)
    begin
        if (accept && last_char)
            sum_reg <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum_data  = sum_reg;

endmodule

// ----- sv/dtm_scale.sv -----
module dtm_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                drain,
    input  dtm_pkg::parse_sum_t sum_data,
    output logic                pp_valid,
    output logic [58:0]         pp_lo,
    output logic [57:0]         pp_hi,
    output logic [2:0]          pp_status
);
    import dtm_pkg::*;

    logic                pp_valid_reg, pp_valid_next;
    logic [58:0]         pp_lo_reg, pp_lo_next;
    logic [57:0]         pp_hi_reg, pp_hi_next;
    logic [2:0]          status_reg, status_next;
    logic [FACTOR_W-1:0] factor;
    logic [FACTOR_W-1:0] factor_use;
    logic [63:0]         limit;

    // Status decode and unit selection
    always_comb
    begin
        factor = FACTOR_S;
        limit  = LIMIT_S;
        case (sum_data.suffix)
            SFX_EMPTY:
            begin
                factor = FACTOR_S;
                limit  = LIMIT_S;
            end
            SFX_S:
            begin
                factor = FACTOR_S;
                limit  = LIMIT_S;
            end
            SFX_MS:
            begin
                factor = FACTOR_MS;
                limit  = LIMIT_MS;
            end
            SFX_M:
            begin
                factor = FACTOR_M;
                limit  = LIMIT_M;
            end
            SFX_H:
            begin
                factor = FACTOR_H;
                limit  = LIMIT_H;
            end
            SFX_D:
            begin
                factor = FACTOR_D;
                limit  = LIMIT_D;
            end
            default:
            begin
                factor = '0;
                limit  = '0;
            end
        endcase

        if (!sum_data.digit_seen || sum_data.range_exceeded)
            status_next = STATUS_NAN;
        else if (sum_data.minus_seen && (sum_data.magnitude != 64'd0))
            status_next = STATUS_NEGATIVE;
        else if (sum_data.suffix == SFX_BAD || !$onehot(sum_data.suffix))
            status_next = STATUS_SUFFIX;
        else if (sum_data.magnitude > limit)
            status_next = STATUS_OVERFLOW;
        else
            status_next = STATUS_OK;

        // A zero factor forces a zero duration on any error
        factor_use = (status_next == STATUS_OK) ? factor : '0;

        // Split product: magnitude halves times the unit factor
        pp_lo_next = {27'b0, sum_data.magnitude[31:0]} * {32'b0, factor_use};
        pp_hi_next = {27'b0, sum_data.magnitude[62:32]} * {31'b0, factor_use};

        if (load)
            pp_valid_next = 1'b1;
        else if (drain)
            pp_valid_next = 1'b0;
        else
            pp_valid_next = pp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pp_valid_reg <= 1'b0;
        else
            pp_valid_reg <= pp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_lo_reg  <= pp_lo_next;
            pp_hi_reg  <= pp_hi_next;
            status_reg <= status_next;
        end
    end

    assign pp_valid  = pp_valid_reg;
    assign pp_lo     = pp_lo_reg;
    assign pp_hi     = pp_hi_reg;
    assign pp_status = status_reg;

endmodule

// ----- sv/dtm_sum.sv -----
module dtm_sum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        drain,
    input  logic [58:0] pp_lo,
    input  logic [57:0] pp_hi,
    input  logic [2:0]  pp_status,
    output logic        res_valid,
    output logic [62:0] res_ms,
    output logic [2:0]  res_status
);
    logic        res_valid_reg, res_valid_next;
    logic [62:0] ms_reg, ms_next;
    logic [2:0]  status_reg;

    // Recombine the partial products, kept to 63 bits
    always_comb
    begin
        ms_next = {4'b0, pp_lo} + {pp_hi[30:0], 32'b0};
        if (load)
            res_valid_next = 1'b1;
        else if (drain)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ms_reg     <= ms_next;
            status_reg <= pp_status;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_ms     = ms_reg;
    assign res_status = status_reg;

endmodule
